>>> src/pft_pkg.sv
// Shared constants, types and helper functions for the pose frame transform.
// Used by pft_cordic and pose_frame_transform_lever_arm; no dependencies.
package pft_pkg;

   localparam int POS_W   = 32;   // Q16.16 position width
   localparam int ANG_W   = 32;   // Q3.29 angle width
   localparam int WIDE_W  = 36;   // angle sums before wrapping
   localparam int CD_W    = 34;   // CORDIC x, y and z width
   localparam int PROD_W  = 66;   // CD_W x POS_W product
   localparam int SUM_W   = 68;   // sum of two products plus rounding
   localparam int TERM_W  = 38;   // rounded term, Q16.16 with headroom
   localparam int OUT_W   = 40;   // position before saturation
   localparam int IDX_W   = 3;
   localparam int CORDIC_STAGES_DEF = 24;

   localparam logic signed [WIDE_W-1:0] ANG_PI       = 36'sd1686629713;
   localparam logic signed [WIDE_W-1:0] ANG_TWO_PI   = 36'sd3373259426;
   localparam logic signed [WIDE_W-1:0] ANG_THREE_PI = 36'sd5059889139;
   localparam logic signed [WIDE_W-1:0] ANG_FOUR_PI  = 36'sd6746518852;
   localparam logic signed [CD_W-1:0]   ANG_HALF_PI  = 34'sd843314857;
   localparam logic signed [CD_W-1:0]   CD_PI        = 34'sd1686629713;
   localparam logic signed [CD_W-1:0]   CORDIC_GAIN  = 34'sd652032874;
   localparam logic signed [SUM_W-1:0]  ROUND_HALF   = 68'sd536870912;

   typedef enum logic [IDX_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_FRAME_ROT  = 3'd2,
      CSR_HEAD_OFF   = 3'd3,
      CSR_ARM_FWD    = 3'd4,
      CSR_ARM_LAT    = 3'd5,
      CSR_ARM_EN     = 3'd6
   } csr_index_type;

   // Wrap into [-pi, pi]; up to two turns each way, picked by parallel compares.
   function automatic logic signed [WIDE_W-1:0] wrap_angle(input logic signed [WIDE_W-1:0] a);
      logic signed [WIDE_W-1:0] v;
      if (a > ANG_THREE_PI) v = a - ANG_FOUR_PI;
      else if (a > ANG_PI) v = a - ANG_TWO_PI;
      else if (a < -ANG_THREE_PI) v = a + ANG_FOUR_PI;
      else if (a < -ANG_PI) v = a + ANG_TWO_PI;
      else v = a;
      return v;
   endfunction

   function automatic logic signed [CD_W-1:0] atan_q29(input int i);
      logic signed [CD_W-1:0] r;
      case (i)
         0: r = 34'sd421657428;  1: r = 34'sd248918915;  2: r = 34'sd131521918;
         3: r = 34'sd66762579;   4: r = 34'sd33510843;   5: r = 34'sd16771758;
         6: r = 34'sd8387925;    7: r = 34'sd4194219;    8: r = 34'sd2097141;
         9: r = 34'sd1048575;
         default: r = (i < 30) ? (34'sd1 <<< (29 - i)) : 34'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [OUT_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > 40'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -40'sd2147483648) r = 32'sh80000000;
      else r = v[POS_W-1:0];
      return r;
   endfunction

endpackage

>>> src/pft_cordic.sv
// Pipelined rotation-mode CORDIC: one quadrant stage plus one stage per iteration.
// Depends on pft_pkg for widths, gain and the arctangent table.
module pft_cordic
   import pft_pkg::*;
#(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic signed [CD_W-1:0] angle,
   output logic signed [CD_W-1:0] cos_out,
   output logic signed [CD_W-1:0] sin_out
);

   logic signed [CD_W-1:0] x_ff [0:STAGES];
   logic signed [CD_W-1:0] y_ff [0:STAGES];
   logic signed [CD_W-1:0] z_ff [0:STAGES];
   logic                   neg_ff [0:STAGES];

   always_ff @(posedge clock) begin
      if (enable) begin
         // fold into [-pi/2, pi/2]
         x_ff[0] <= CORDIC_GAIN;
         y_ff[0] <= '0;
         if (angle > ANG_HALF_PI) begin
            z_ff[0]   <= angle - CD_PI;
            neg_ff[0] <= 1'b1;
         end else if (angle < -ANG_HALF_PI) begin
            z_ff[0]   <= angle + CD_PI;
            neg_ff[0] <= 1'b1;
         end else begin
            z_ff[0]   <= angle;
            neg_ff[0] <= 1'b0;
         end
         // one micro-rotation per stage
         for (int i = 0; i < STAGES; i++) begin
            neg_ff[i+1] <= neg_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q29(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q29(i);
            end
         end
      end
   end

   assign cos_out = neg_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
   assign sin_out = neg_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];

endmodule

>>> src/pose_frame_transform_lever_arm.sv
// Top level of the pose frame transform with lever-arm compensation.
// Depends on pft_pkg and pft_cordic (two instances: frame rotation, heading).
//
//  channel | direction | beat contents (low bits first)
//  req_    | in        | tdata: src_x[31:0], src_y[63:32], src_yaw[95:64]
//  rsp_    | out       | tdata: dst_x[31:0], dst_y[63:32], dst_heading[95:64]
//  csr_    | in        | csr_index selects register 0..6, csr_data carries the value
//
// One pose per cycle while rsp_ is not stalled; the depth is set by the CORDIC
// iteration stages. Reset (synchronous, active high) clears the valid bits and
// the configuration registers, but sets the lever-arm enable.
// A stall on rsp_ freezes the whole pipeline; req_tready drops only while a
// result is waiting, so nothing is lost or repeated.
module pose_frame_transform_lever_arm
   import pft_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [3*POS_W-1:0]    req_tdata,   // src_x, src_y, src_yaw
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [3*POS_W-1:0]    rsp_tdata,   // dst_x, dst_y, dst_heading
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [IDX_W-1:0]      csr_index,
   input  logic [POS_W-1:0]      csr_data
);

   localparam int LAT = CORDIC_STAGES + 1;   // depth of each CORDIC pipeline

   // configuration registers
   logic signed [POS_W-1:0] origin_x_ff, origin_y_ff, frame_rot_ff, head_off_ff;
   logic signed [POS_W-1:0] arm_fwd_ff, arm_lat_ff;
   logic                    arm_en_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         frame_rot_ff <= '0;
         head_off_ff  <= '0;
         arm_fwd_ff   <= '0;
         arm_lat_ff   <= '0;
         arm_en_ff    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:  origin_x_ff  <= csr_data;
            CSR_ORIGIN_Y:  origin_y_ff  <= csr_data;
            CSR_FRAME_ROT: frame_rot_ff <= csr_data;
            CSR_HEAD_OFF:  head_off_ff  <= csr_data;
            CSR_ARM_FWD:   arm_fwd_ff   <= csr_data;
            CSR_ARM_LAT:   arm_lat_ff   <= csr_data;
            CSR_ARM_EN:    arm_en_ff    <= csr_data[0];
            default: ;     // drop writes beyond the register list
         endcase
      end
   end

   // global advance: hold everything while the output beat is not taken
   logic adv;
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: heading sum and wraps
   logic signed [POS_W-1:0]  in_x, in_y, in_yaw;
   logic signed [WIDE_W-1:0] head_in, rot_in;
   logic                     v1_ff;
   logic signed [POS_W-1:0]  px1_ff, py1_ff;
   logic signed [WIDE_W-1:0] head1_ff, rot1_ff;

   assign in_x   = req_tdata[POS_W-1:0];
   assign in_y   = req_tdata[2*POS_W-1:POS_W];
   assign in_yaw = req_tdata[3*POS_W-1:2*POS_W];
   assign head_in = wrap_angle(WIDE_W'(frame_rot_ff) + WIDE_W'(head_off_ff)
                               - WIDE_W'(in_yaw));
   assign rot_in  = wrap_angle(WIDE_W'(frame_rot_ff));

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px1_ff   <= in_x;
         py1_ff   <= in_y;
         head1_ff <= head_in;
         rot1_ff  <= rot_in;
      end
   end

   // CORDIC pair, with payload carried alongside
   logic signed [CD_W-1:0] cr, sr, ch, sh;

   pft_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_rot (
      .clock(clock), .enable(adv), .angle(rot1_ff[CD_W-1:0]),
      .cos_out(cr), .sin_out(sr)
   );
   pft_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_head (
      .clock(clock), .enable(adv), .angle(head1_ff[CD_W-1:0]),
      .cos_out(ch), .sin_out(sh)
   );

   logic                    dv_ff   [0:LAT-1];
   logic signed [POS_W-1:0] dpx_ff  [0:LAT-1];
   logic signed [POS_W-1:0] dpy_ff  [0:LAT-1];
   logic signed [ANG_W-1:0] dhd_ff  [0:LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) dv_ff[k] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= v1_ff;
         for (int k = 1; k < LAT; k++) dv_ff[k] <= dv_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dpx_ff[0] <= px1_ff;
         dpy_ff[0] <= py1_ff;
         dhd_ff[0] <= head1_ff[ANG_W-1:0];
         for (int k = 1; k < LAT; k++) begin
            dpx_ff[k] <= dpx_ff[k-1];
            dpy_ff[k] <= dpy_ff[k-1];
            dhd_ff[k] <= dhd_ff[k-1];
         end
      end
   end

   // multiply stage: eight products
   logic                     vm_ff;
   logic signed [PROD_W-1:0] crpx_ff, srpy_ff, srpx_ff, crpy_ff;
   logic signed [PROD_W-1:0] chaf_ff, shal_ff, shaf_ff, chal_ff;
   logic signed [ANG_W-1:0]  hdm_ff;

   always_ff @(posedge clock) begin
      if (reset) vm_ff <= 1'b0;
      else if (adv) vm_ff <= dv_ff[LAT-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         crpx_ff <= cr * dpx_ff[LAT-1];
         srpy_ff <= sr * dpy_ff[LAT-1];
         srpx_ff <= sr * dpx_ff[LAT-1];
         crpy_ff <= cr * dpy_ff[LAT-1];
         chaf_ff <= ch * arm_fwd_ff;
         shal_ff <= sh * arm_lat_ff;
         shaf_ff <= sh * arm_fwd_ff;
         chal_ff <= ch * arm_lat_ff;
         hdm_ff  <= dhd_ff[LAT-1];
      end
   end

   // round stage: Q18.46 sums back to Q16.16
   logic                     vr_ff;
   logic signed [SUM_W-1:0]  sx_in, sy_in, ax_in, ay_in;
   logic signed [TERM_W-1:0] tx_ff, ty_ff, ax_ff, ay_ff;
   logic signed [ANG_W-1:0]  hdr_ff;

   assign sx_in = (SUM_W'(crpx_ff) - SUM_W'(srpy_ff) + ROUND_HALF) >>> 30;
   assign sy_in = (SUM_W'(srpx_ff) + SUM_W'(crpy_ff) + ROUND_HALF) >>> 30;
   assign ax_in = (SUM_W'(chaf_ff) - SUM_W'(shal_ff) + ROUND_HALF) >>> 30;
   assign ay_in = (SUM_W'(shaf_ff) + SUM_W'(chal_ff) + ROUND_HALF) >>> 30;

   always_ff @(posedge clock) begin
      if (reset) vr_ff <= 1'b0;
      else if (adv) vr_ff <= vm_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tx_ff  <= sx_in[TERM_W-1:0];
         ty_ff  <= sy_in[TERM_W-1:0];
         ax_ff  <= ax_in[TERM_W-1:0];
         ay_ff  <= ay_in[TERM_W-1:0];
         hdr_ff <= hdm_ff;
      end
   end

   // output stage: shift by origin, take off the lever arm when enabled, saturate
   logic signed [OUT_W-1:0] dx_in, dy_in;
   logic signed [POS_W-1:0] dx_ff, dy_ff, hd_ff;

   assign dx_in = OUT_W'(tx_ff) + OUT_W'(origin_x_ff)
                  - (arm_en_ff ? OUT_W'(ax_ff) : '0);
   assign dy_in = OUT_W'(ty_ff) + OUT_W'(origin_y_ff)
                  - (arm_en_ff ? OUT_W'(ay_ff) : '0);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= vr_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff <= sat_pos(dx_in);
         dy_ff <= sat_pos(dy_in);
         hd_ff <= hdr_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {hd_ff, dy_ff, dx_ff};

   // checks
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hd_ff <= 32'sd1686629713 && hd_ff >= -32'sd1686629713))
      else $error("heading out of wrapped range");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready disagrees with output stall");

   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(dx_ff) && $stable(hd_ff)))
      else $error("stalled result changed");

endmodule

>>> tb/pft_checker.sv
// Checker for the pose frame transform: watches req_, rsp_ and csr_ beats,
// predicts each pose result and compares it. Depends on pft_pkg only.
module pft_checker
   import pft_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [95:0]       req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [95:0]       rsp_tdata,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [31:0]       csr_data,
   output int                fail_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint PI_Q29      = 64'sd1686629713;
   localparam longint TWO_PI_Q29  = 64'sd3373259426;
   localparam longint HALF_PI_Q29 = 64'sd843314857;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam int     STAGES      = CORDIC_STAGES_DEF;

   logic signed [31:0] org_x, org_y, rot_reg, head_off, lever_fwd, lever_lat;
   logic               lever_on;
   logic [95:0]        pose_queue[$];

   function automatic longint angle_wrap(input longint a);
      longint v;
      v = a;
      repeat (2) if (v > PI_Q29) v -= TWO_PI_Q29;
      repeat (2) if (v < -PI_Q29) v += TWO_PI_Q29;
      return v;
   endfunction

   function automatic longint tan_step(input int i);
      longint tbl[10];
      tbl = '{421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
              8387925, 4194219, 2097141, 1048575};
      if (i < 10) return tbl[i];
      return (i < 30) ? (64'sd1 <<< (29 - i)) : 0;
   endfunction

   function automatic void sin_cos(input longint ang, output longint c, output longint s);
      longint x, y, z, nx;
      bit flip;
      x = GAIN_Q30; y = 0; z = ang; flip = 0;
      if (z > HALF_PI_Q29) begin
         z -= PI_Q29; flip = 1;
      end else if (z < -HALF_PI_Q29) begin
         z += PI_Q29; flip = 1;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= tan_step(i);
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += tan_step(i);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // round Q18.46 difference down to Q16.16; products stay well under 64 bits
   function automatic longint round_term(input longint p, input longint q);
      return (p - q + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic logic [95:0] transform_pose(input logic [95:0] d);
      longint px, py, yaw, hd, cr, sr, ch, sh, dx, dy;
      px  = longint'($signed(d[31:0]));
      py  = longint'($signed(d[63:32]));
      yaw = longint'($signed(d[95:64]));
      hd = angle_wrap(-yaw + longint'(rot_reg) + longint'(head_off));
      sin_cos(angle_wrap(longint'(rot_reg)), cr, sr);
      dx = round_term(cr * px, sr * py) + longint'(org_x);
      dy = round_term(sr * px, -(cr * py)) + longint'(org_y);
      if (lever_on) begin
         sin_cos(hd, ch, sh);
         dx -= round_term(ch * longint'(lever_fwd), sh * longint'(lever_lat));
         dy -= round_term(sh * longint'(lever_fwd), -(ch * longint'(lever_lat)));
      end
      return {hd[31:0], clamp32(dy), clamp32(dx)};
   endfunction

   assign pending_count = pose_queue.size();

   always @(posedge clock) begin
      logic [95:0] want;
      if (reset) begin
         org_x <= '0; org_y <= '0; rot_reg <= '0; head_off <= '0;
         lever_fwd <= '0; lever_lat <= '0; lever_on <= 1'b1;
         pose_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_ORIGIN_X:  org_x <= csr_data;
               CSR_ORIGIN_Y:  org_y <= csr_data;
               CSR_FRAME_ROT: rot_reg <= csr_data;
               CSR_HEAD_OFF:  head_off <= csr_data;
               CSR_ARM_FWD:   lever_fwd <= csr_data;
               CSR_ARM_LAT:   lever_lat <= csr_data;
               CSR_ARM_EN:    lever_on <= csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pose_queue = {pose_queue, transform_pose(req_tdata)};
         if (rsp_tvalid && rsp_tready) begin
            if (pose_queue.size() == 0) begin
               $error("unexpected result beat %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = pose_queue.pop_front();
               if (want[31:0] !== rsp_tdata[31:0])
                  $error("dst_x expected %h actual %h", want[31:0], rsp_tdata[31:0]);
               if (want[63:32] !== rsp_tdata[63:32])
                  $error("dst_y expected %h actual %h", want[63:32], rsp_tdata[63:32]);
               if (want[95:64] !== rsp_tdata[95:64])
                  $error("dst_heading expected %h actual %h", want[95:64],
                         rsp_tdata[95:64]);
               if (want !== rsp_tdata) fail_count <= fail_count + 1;
            end
         end
      end
   end
endmodule

>>> tb/tb_pose_frame_transform_lever_arm.sv
// Testbench top for the pose frame transform: drives poses and register
// writes, stalls the result side, and reports the verdict. Needs pft_checker.
module tb_pose_frame_transform_lever_arm
   import pft_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     LATENCY  = CORDIC_STAGES_DEF + 5;
   localparam longint MAX_CYC  = 400000;
   localparam int     PI_Q29   = 1686629713;

   logic              clock, reset;
   logic              req_tvalid, req_tready;
   logic [95:0]       req_tdata;          // src_x, src_y, src_yaw
   logic              rsp_tvalid, rsp_tready;
   logic [95:0]       rsp_tdata;          // dst_x, dst_y, dst_heading
   logic              csr_valid, csr_ready;
   logic [IDX_W-1:0]  csr_index;
   logic [31:0]       csr_data;
   int                fail_count, pending_count;
   longint            cycle_count;

   pose_frame_transform_lever_arm u_top (.*);

   pft_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Hard stop on hang.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > MAX_CYC) begin
            $display("pose_frame_transform_lever_arm test failed");
            $finish;
         end
      end
   end

   // Receiver: stall on its own pattern, with quiet stretches of no stall.
   initial begin
      int mode;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (cycle_count % 300 == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   // Random angle: always in range, some near the ends of plus or minus pi.
   function automatic logic [31:0] rand_angle();
      case ($urandom_range(0, 4))
         0: return PI_Q29 - $urandom_range(0, 3);
         1: return -PI_Q29 + $urandom_range(0, 3);
         default: return $urandom_range(0, 2 * PI_Q29) - PI_Q29;
      endcase
   endfunction

   // Random position: small, mid or full 32-bit range.
   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
         1: return $urandom_range(0, 32'h0FFFFFFF) - 32'h08000000;
         default: return $urandom;
      endcase
   endfunction

   // Present one register beat; the caller drops csr_valid after the last one.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic send_pose(input logic [31:0] x, y, yaw);
      req_tdata  <= {yaw, y, x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold valid low for a random gap between bursts; sometimes there is no gap.
   task automatic burst_gap();
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drain all results and let the pipeline settle before touching registers.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic set_config(input logic [31:0] ox, oy, rot, hoff, af, al,
                             input logic en);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_FRAME_ROT, rot);
      write_reg(CSR_HEAD_OFF, hoff);
      write_reg(CSR_ARM_FWD, af);
      write_reg(CSR_ARM_LAT, al);
      write_reg(CSR_ARM_EN, {31'd0, en});
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      int left;
      left = count;
      while (left > 0) begin
         for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--) begin
            send_pose(rand_pos(), rand_pos(), rand_angle());
            left--;
         end
         burst_gap();
      end
   endtask

   initial begin
      req_tvalid = 0; req_tdata = '0;
      csr_valid = 0; csr_index = '0; csr_data = '0;
      reset = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: reset config (lever arm on, zero arm), then extremes.
      send_pose(32'h0, 32'h0, 32'h0);
      send_pose(32'h7FFFFFFF, 32'h80000000, PI_Q29);
      send_pose(32'h80000000, 32'h7FFFFFFF, -PI_Q29);
      send_pose(32'hFFFFFFFF, 32'h00010000, 32'h1);
      drain();
      // Frame rotation past half pi exercises the quadrant fold; big origin saturates.
      set_config(32'h7FFFFFFF, 32'h80000000, PI_Q29, PI_Q29, 32'h7FFFFFFF,
                 32'h80000000, 1'b1);
      send_pose(32'h7FFFFFFF, 32'h7FFFFFFF, -PI_Q29);
      send_pose(32'h80000000, 32'h80000000, PI_Q29);
      send_pose(32'h00010000, 32'hFFFF0000, 32'd843314858);
      send_pose(32'h0, 32'h0, -32'sd843314858);
      drain();
      set_config(32'h80000000, 32'h7FFFFFFF, -PI_Q29, -PI_Q29, 32'h80000000,
                 32'h7FFFFFFF, 1'b0);
      send_pose(32'h7FFFFFFF, 32'h80000000, PI_Q29);
      send_pose(32'h80000000, 32'h7FFFFFFF, -PI_Q29);
      send_pose(32'h12345678, 32'hEDCBA987, 32'd843314857);
      drain();
      // Out-of-range register angles: wrap covers any 32-bit value.
      set_config(32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00020000,
                 32'hFFFE0000, 1'b1);
      send_pose(32'h00010000, 32'h00010000, PI_Q29);
      send_pose(32'h00010000, 32'h00010000, -PI_Q29);
      send_pose(32'hAAAAAAAA, 32'h55555555, 32'h0);
      drain();

      // Random phases under several random settings.
      for (int ph = 0; ph < 6; ph++) begin
         set_config(rand_pos(), rand_pos(),
                    ($urandom_range(0, 4) == 0) ? $urandom : rand_angle(),
                    rand_angle(), rand_pos(), rand_pos(), ($urandom_range(0, 3) != 0));
         random_phase(205);
         drain();
      end

      if (fail_count == 0) $display("pose_frame_transform_lever_arm test passed");
      else $display("pose_frame_transform_lever_arm test failed");
      $finish;
   end
endmodule

>>> filelist.f
src/pft_pkg.sv
src/pft_cordic.sv
src/pose_frame_transform_lever_arm.sv
tb/pft_checker.sv
tb/tb_pose_frame_transform_lever_arm.sv
